>>> rtl/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants of the circular FIFO buffer: field widths,
// command and status codes, and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_W     = 9;
    localparam int DEPTH_DEF = 256;

    localparam logic [CNT_W-1:0] LEN_RESET = 9'd256;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_REMOVED = 3'd1,
        ST_FLUSHED = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_BAD_LEN = 3'd5
    } t_status;

    typedef struct packed {
        logic load;   // latch the incoming transaction
        logic exec;   // carry out the latched command
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> rtl/cfb_ram.sv
// ----------------------------------------------------------------------------
// cfb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/cfb_ctrl.sv
// ----------------------------------------------------------------------------
// cfb_ctrl
// Controller: sequences each transaction through execute and response
// and drives the busy and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_ctrl
    import cfb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      o_valid,
    output t_dp_cmd   o_dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;
    logic   w_accept;

    // A new transaction may enter while the previous result is on the ports.
    assign w_accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE, S_RESP: begin
                    r_valid <= 1'b0;
                    if (w_accept) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state <= S_RESP;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign busy          = r_busy;
    assign o_valid       = r_valid;
    assign o_dp_cmd.load = w_accept;
    assign o_dp_cmd.exec = (r_state == S_EXEC);

endmodule

`default_nettype wire

>>> rtl/cfb_dpath.sv
// ----------------------------------------------------------------------------
// cfb_dpath
// Datapath: length register, ring indices, entry count, entry store and
// the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_dpath
    import cfb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_dp_cmd,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    input  wire logic [1:0]        i_command,
    input  wire logic [DATA_W-1:0] i_data_in,
    output logic      [2:0]        o_status,
    output logic      [DATA_W-1:0] o_data_out,
    output logic      [CNT_W-1:0]  o_item_count,
    output logic                   o_is_full,
    output logic                   o_is_empty
);

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int CAP    = (DEPTH > 511) ? 511 : DEPTH;
    localparam logic [CNT_W-1:0] LEN_CAP = CNT_W'(CAP);

    logic [CNT_W-1:0]  r_len;
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_din;
    t_status           r_status, n_status;
    logic              r_full, n_full;
    logic              r_empty, n_empty;
    logic              r_use_rd, n_use_rd;

    logic [CNT_W-1:0]  w_len;
    logic [CMP_W-1:0]  w_wr_inc;
    logic [CMP_W-1:0]  w_rd_inc;
    logic [AW-1:0]     w_wr_next;
    logic [AW-1:0]     w_rd_next;
    logic [AW-1:0]     w_last;
    logic              ram_en;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [DATA_W-1:0] ram_rdata;

    // Lengths beyond the store act as the full store.
    assign w_len = (CMP_W'(r_len) > CMP_W'(CAP)) ? LEN_CAP : r_len;

    assign w_wr_inc  = CMP_W'(r_wr) + CMP_W'(1);
    assign w_rd_inc  = CMP_W'(r_rd) + CMP_W'(1);
    assign w_wr_next = (w_wr_inc >= CMP_W'(w_len)) ? '0 : w_wr_inc[AW-1:0];
    assign w_rd_next = (w_rd_inc >= CMP_W'(w_len)) ? '0 : w_rd_inc[AW-1:0];
    assign w_last    = (r_wr == '0) ? AW'(w_len - CNT_W'(1)) : (r_wr - AW'(1));

    always_comb begin
        n_wr     = r_wr;
        n_rd     = r_rd;
        n_count  = r_count;
        n_status = ST_ADDED;
        n_use_rd = 1'b0;
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = r_rd;
        if (w_len == '0) begin
            n_status = ST_BAD_LEN;
        end else begin
            case (r_cmd)
                CMD_ADD: begin
                    if (r_count >= w_len) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_en   = 1'b1;
                        ram_we   = 1'b1;
                        ram_addr = r_wr;
                        n_wr     = w_wr_next;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ram_en   = 1'b1;
                        n_use_rd = 1'b1;
                        n_rd     = w_rd_next;
                        n_count  = r_count - CNT_W'(1);
                        n_status = ST_REMOVED;
                    end
                end
                CMD_FLUSH: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ram_en   = 1'b1;
                        ram_addr = w_last;
                        n_use_rd = 1'b1;
                        n_rd     = r_wr;
                        n_count  = '0;
                        n_status = ST_FLUSHED;
                    end
                end
                default: begin
                    n_status = ST_ADDED;
                end
            endcase
        end
        n_full  = (w_len != '0) && (n_count == w_len);
        n_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_RESET;
            r_wr     <= '0;
            r_rd     <= '0;
            r_count  <= '0;
            r_use_rd <= 1'b0;
        end else if (i_cfg_we) begin
            // A new length empties the FIFO.
            r_len   <= i_cfg_data;
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else if (i_dp_cmd.exec) begin
            r_wr     <= n_wr;
            r_rd     <= n_rd;
            r_count  <= n_count;
            r_use_rd <= n_use_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd <= t_cmd'(i_command);
            r_din <= i_data_in;
        end
        if (i_dp_cmd.exec) begin
            r_status <= n_status;
            r_full   <= n_full;
            r_empty  <= n_empty;
        end
    end

    cfb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_din),
        .o_rdata (ram_rdata)
    );

    assign o_status     = r_status;
    assign o_data_out   = r_use_rd ? ram_rdata : '0;
    assign o_item_count = r_count;
    assign o_is_full    = r_full;
    assign o_is_empty   = r_empty;

endmodule

`default_nettype wire

>>> rtl/circular_fifo_buffer.sv
// ----------------------------------------------------------------------------
// circular_fifo_buffer
// Ring-buffer FIFO of 32-bit words with a programmable length.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge where start is high and busy is low.
// Its result is driven on the result ports for the one cycle that follows
// the next edge, marked by o_valid. The receiver cannot stall, so it must
// take the result then. Busy stays high while a command executes against
// the entry store, so no new command is taken before that; read data comes
// from the registered read of its single RAM port. The next command may be
// offered while a result is shown.
// Writing the length register empties the FIFO; write it only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_buffer
    import cfb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_command,
    input  wire logic [DATA_W-1:0] i_data_in,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    output logic                   o_valid,
    output logic      [2:0]        o_status,
    output logic      [DATA_W-1:0] o_data_out,
    output logic      [CNT_W-1:0]  o_item_count,
    output logic                   o_is_full,
    output logic                   o_is_empty
);

    t_dp_cmd dp_cmd;

    cfb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_dp_cmd (dp_cmd)
    );

    cfb_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_data_in    (i_data_in),
        .o_status     (o_status),
        .o_data_out   (o_data_out),
        .o_item_count (o_item_count),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty)
    );

endmodule

`default_nettype wire

>>> rtl/cfb_checker.sv
// ----------------------------------------------------------------------------
// cfb_checker
// Port-level checks of the circular FIFO buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_checker
    import cfb_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_valid,
    input wire logic [2:0]        o_status,
    input wire logic [DATA_W-1:0] o_data_out,
    input wire logic [CNT_W-1:0]  o_item_count,
    input wire logic              o_is_full,
    input wire logic              o_is_empty
);

    // Every accepted transaction yields o_valid once its execute state has passed.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result missing two cycles after accepted transaction");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_full && o_is_empty))
        else $error("full and empty reported together");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_item_count == '0)))
        else $error("empty flag disagrees with item count");

    a_bad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_BAD_LEN)) |->
        (o_is_empty && !o_is_full && (o_item_count == '0) && (o_data_out == '0)))
        else $error("invalid length result carries state");

endmodule

bind circular_fifo_buffer cfb_checker u_cfb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_data_out   (o_data_out),
    .o_item_count (o_item_count),
    .o_is_full    (o_is_full),
    .o_is_empty   (o_is_empty)
);

`default_nettype wire
